>>> rtl/msp_pkg.sv
// Shared types and constants for the serial protocol v1 frame parser.
package msp_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
   localparam logic [7:0] CHAR_M      = 8'h4D;  // 'M'
   localparam logic [7:0] CHAR_LT     = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_GT     = 8'h3E;  // '>'

   typedef enum logic [6:0] {
      PH_IDLE      = 7'b0000001,
      PH_VERSION   = 7'b0000010,
      PH_DIRECTION = 7'b0000100,
      PH_SIZE      = 7'b0001000,
      PH_CMD       = 7'b0010000,
      PH_PAYLOAD   = 7'b0100000,
      PH_CHECKSUM  = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE = 3'd0,
      EV_HDR  = 3'd1,
      EV_DATA = 3'd2,
      EV_GOOD = 3'd3,
      EV_CKS  = 3'd4
   } event_type;

   typedef struct packed {
      phase_type  phase;
      logic       dir_flag;
      logic [7:0] declared_size;
      logic [7:0] cmd;
      logic [7:0] running_xor;
      logic [7:0] byte_count;
   } state_type;

   typedef struct packed {
      event_type  ev;
      logic [7:0] data_byte;
      logic [7:0] payload_index;
      logic [7:0] command;
      logic [7:0] frame_size;
      logic       is_reply;
   } result_type;

endpackage

>>> rtl/msp_step.sv
// Per-word parser step: next state and result for one received word.
module msp_step (
   input  msp_pkg::state_type  state,
   input  logic [7:0]          rx_byte,
   output msp_pkg::state_type  state_next,
   output msp_pkg::result_type result
);

   logic [7:0] count_inc;

   assign count_inc = state.byte_count + 8'd1;

   always_comb begin
      state_next = state;
      result.ev = msp_pkg::EV_NONE;
      result.data_byte = 8'd0;
      result.payload_index = 8'd0;

      case (state.phase)
         msp_pkg::PH_VERSION: begin
            if (rx_byte == msp_pkg::CHAR_M) begin
               state_next.phase = msp_pkg::PH_DIRECTION;
            end else begin
               state_next.phase = msp_pkg::PH_IDLE;
               result.ev = msp_pkg::EV_HDR;
            end
         end
         msp_pkg::PH_DIRECTION: begin
            if (rx_byte == msp_pkg::CHAR_LT) begin
               state_next.dir_flag = 1'b0;
               state_next.phase = msp_pkg::PH_SIZE;
            end else if (rx_byte == msp_pkg::CHAR_GT) begin
               state_next.dir_flag = 1'b1;
               state_next.phase = msp_pkg::PH_SIZE;
            end else begin
               state_next.phase = msp_pkg::PH_IDLE;
               result.ev = msp_pkg::EV_HDR;
            end
         end
         msp_pkg::PH_SIZE: begin
            state_next.running_xor = rx_byte;
            state_next.declared_size = rx_byte;
            state_next.phase = msp_pkg::PH_CMD;
         end
         msp_pkg::PH_CMD: begin
            state_next.cmd = rx_byte;
            state_next.running_xor = state.running_xor ^ rx_byte;
            state_next.byte_count = 8'd0;
            state_next.phase = (state.declared_size != 8'd0) ? msp_pkg::PH_PAYLOAD
                                                              : msp_pkg::PH_CHECKSUM;
         end
         msp_pkg::PH_PAYLOAD: begin
            result.ev = msp_pkg::EV_DATA;
            result.data_byte = rx_byte;
            result.payload_index = state.byte_count;
            state_next.running_xor = state.running_xor ^ rx_byte;
            if (count_inc == state.declared_size) begin
               state_next.byte_count = 8'd0;
               state_next.phase = msp_pkg::PH_CHECKSUM;
            end else begin
               state_next.byte_count = count_inc;
            end
         end
         msp_pkg::PH_CHECKSUM: begin
            state_next.phase = msp_pkg::PH_IDLE;
            result.ev = (state.running_xor == rx_byte) ? msp_pkg::EV_GOOD
                                                       : msp_pkg::EV_CKS;
         end
         default: begin
            // idle
            if (rx_byte == msp_pkg::CHAR_DOLLAR) begin
               state_next.phase = msp_pkg::PH_VERSION;
            end else begin
               state_next.phase = msp_pkg::PH_IDLE;
               result.ev = msp_pkg::EV_HDR;
            end
         end
      endcase

      // frame fields as they stand once this word is taken in
      result.command = state_next.cmd;
      result.frame_size = state_next.declared_size;
      result.is_reply = state_next.dir_flag;

      // a good frame wipes the frame registers after reporting them
      if (result.ev == msp_pkg::EV_GOOD) begin
         state_next.dir_flag = 1'b0;
         state_next.declared_size = 8'd0;
         state_next.cmd = 8'd0;
         state_next.running_xor = 8'd0;
         state_next.byte_count = 8'd0;
      end
   end

endmodule

>>> rtl/msp_v1_frame_parser_unit.sv
// Top level of the serial protocol v1 frame parser: handshake, registers, step logic.
//
//   channel | direction | ports                                   | per word
//   --------+-----------+-----------------------------------------+-----------------
//   req     | in        | req_valid req_ready req_rx_byte         | one received byte
//   rsp     | out       | rsp_valid rsp_ready rsp_event_res ...   | one parse event
//
// One word per cycle sustained while rsp does not stall. A taken word sits in the
// input register; once the result slot is free, the step logic updates the parser
// state and loads the result register, which offers the result on rsp.
// Reset clears parser state and both valid flags; the parser starts idle.
// When rsp stalls, one result waits in the result register and one word in the
// input register; req_ready drops only when both are full.
module msp_v1_frame_parser_unit (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_payload_index,
   output logic [7:0] rsp_command,
   output logic [7:0] rsp_frame_size,
   output logic       rsp_is_reply
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // parser state
   msp_pkg::state_type state_ff, state_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   msp_pkg::result_type result_ff, result_in;

   logic advance;

   // move the held word through the step when the result slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   msp_step u_step (
      .state      (state_ff),
      .rx_byte    (in_byte_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: msp_pkg::PH_IDLE, dir_flag: 1'b0, declared_size: 8'd0,
                           cmd: 8'd0, running_xor: 8'd0, byte_count: 8'd0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_res     = 3'(result_ff.ev);
   assign rsp_data_byte     = result_ff.data_byte;
   assign rsp_payload_index = result_ff.payload_index;
   assign rsp_command       = result_ff.command;
   assign rsp_frame_size    = result_ff.frame_size;
   assign rsp_is_reply      = result_ff.is_reply;

endmodule
